FILE: rtl/core/spcp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spcp_pkg;

    // magnitude width of lengths, distances and quotients
    localparam int MAG_W  = 32;
    // width of squared lengths and products
    localparam int PROD_W = 2 * MAG_W;

    // pair kinds
    typedef enum logic [1:0] {
        FUNC_CC = 2'd0,
        FUNC_BB = 2'd1,
        FUNC_CB = 2'd2,
        FUNC_BC = 2'd3
    } spcp_func_t;

    // one pair test as it arrives
    typedef struct packed {
        spcp_func_t         func;
        logic signed [31:0] self_x;
        logic signed [31:0] self_y;
        logic [30:0]        self_a;
        logic [30:0]        self_b;
        logic signed [31:0] other_x;
        logic signed [31:0] other_y;
        logic [30:0]        other_a;
        logic [30:0]        other_b;
        logic               apply_push;
        logic               dynamic;
    } spcp_item_t;

    // sideband that rides along the square root pipeline
    typedef struct packed {
        spcp_func_t         func;
        logic               push;
        logic               dyn;
        logic               hit;
        logic signed [33:0] bmx;
        logic signed [33:0] bmy;
        logic               x_neg;
        logic               y_neg;
        logic [MAG_W-1:0]   ax;
        logic [MAG_W-1:0]   ay;
        logic [MAG_W-1:0]   rad;
    } spcp_root_side_t;

    // sideband that rides along the divider pipeline
    typedef struct packed {
        spcp_func_t         func;
        logic               push;
        logic               dyn;
        logic               hit;
        logic signed [33:0] bmx;
        logic signed [33:0] bmy;
        logic               x_neg;
        logic               y_neg;
        logic               dist_zero;
        logic               over_pos;
        logic [MAG_W-1:0]   amt;
    } spcp_quot_side_t;

endpackage

`default_nettype wire

FILE: rtl/core/spcp_if.sv
`timescale 1ns / 1ps
`default_nettype none

// pair test channel
interface spcp_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic signed [31:0] self_x;
    logic signed [31:0] self_y;
    logic [30:0]        self_a;
    logic [30:0]        self_b;
    logic signed [31:0] other_x;
    logic signed [31:0] other_y;
    logic [30:0]        other_a;
    logic [30:0]        other_b;
    logic               apply_push;
    logic               dynamic;

    modport source (
        output valid, func, self_x, self_y, self_a, self_b,
               other_x, other_y, other_a, other_b, apply_push, dynamic,
        input  ready
    );
    modport sink (
        input  valid, func, self_x, self_y, self_a, self_b,
               other_x, other_y, other_a, other_b, apply_push, dynamic,
        output ready
    );
endinterface

// result channel
interface spcp_out_if;
    logic               valid;
    logic               ready;
    logic               colliding;
    logic               grounded;
    logic signed [31:0] move_x;
    logic signed [31:0] move_y;
    logic               moved;

    modport source (
        output valid, colliding, grounded, move_x, move_y, moved,
        input  ready
    );
    modport sink (
        input  valid, colliding, grounded, move_x, move_y, moved,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/core/spcp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module spcp_front
    import spcp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  in_valid,
    input  spcp_item_t            in_item,
    output logic                  out_valid,
    output spcp_root_side_t       out_side,
    output logic [PROD_W-1:0]     out_n
);

    // stage 1: box edges and clamp bounds
    logic                     box_other;
    logic signed [31:0]       bx;
    logic signed [31:0]       by;
    logic [30:0]              bw;
    logic [30:0]              bh;
    logic signed [31:0]       cx_next;
    logic signed [31:0]       cy_next;
    logic [30:0]              cr;
    logic signed [32:0]       lox_next;
    logic signed [32:0]       hix_next;
    logic signed [32:0]       loy_next;
    logic signed [32:0]       hiy_next;
    logic [MAG_W-1:0]         rad_next;

    logic                     s1_v_reg;
    spcp_func_t               s1_func_reg;
    logic                     s1_push_reg;
    logic                     s1_dyn_reg;
    logic signed [31:0]       s1_cx_reg;
    logic signed [31:0]       s1_cy_reg;
    logic signed [32:0]       s1_lox_reg;
    logic signed [32:0]       s1_hix_reg;
    logic signed [32:0]       s1_loy_reg;
    logic signed [32:0]       s1_hiy_reg;
    logic signed [32:0]       s1_slx_reg;
    logic signed [32:0]       s1_shx_reg;
    logic signed [32:0]       s1_sly_reg;
    logic signed [32:0]       s1_shy_reg;
    logic                     s1_ltx_reg;
    logic                     s1_lty_reg;
    logic [MAG_W-1:0]         s1_rad_reg;

    always_comb
    begin
        box_other = (in_item.func != FUNC_BC);
        bx        = box_other ? in_item.other_x : in_item.self_x;
        by        = box_other ? in_item.other_y : in_item.self_y;
        bw        = box_other ? in_item.other_a : in_item.self_a;
        bh        = box_other ? in_item.other_b : in_item.self_b;
        cx_next   = box_other ? in_item.self_x : in_item.other_x;
        cy_next   = box_other ? in_item.self_y : in_item.other_y;
        cr        = box_other ? in_item.self_a : in_item.other_a;
        lox_next  = 33'(bx) - $signed({2'b00, bw});
        hix_next  = 33'(bx) + $signed({2'b00, bw});
        loy_next  = 33'(by) - $signed({2'b00, bh});
        hiy_next  = 33'(by) + $signed({2'b00, bh});
        rad_next  = MAG_W'(cr);
        unique case (in_item.func)
            FUNC_CC:
            begin
                // a circle pair is a clamp onto a single point
                lox_next = 33'(in_item.other_x);
                hix_next = 33'(in_item.other_x);
                loy_next = 33'(in_item.other_y);
                hiy_next = 33'(in_item.other_y);
                rad_next = MAG_W'(in_item.self_a) + MAG_W'(in_item.other_a);
            end
            FUNC_BB:
            begin
                rad_next = '0;
            end
            FUNC_CB, FUNC_BC:
            begin
                rad_next = MAG_W'(cr);
            end
            default:
            begin
                rad_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else if (adv)
            s1_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_func_reg <= in_item.func;
            s1_push_reg <= in_item.apply_push;
            s1_dyn_reg  <= in_item.dynamic;
            s1_cx_reg   <= cx_next;
            s1_cy_reg   <= cy_next;
            s1_lox_reg  <= lox_next;
            s1_hix_reg  <= hix_next;
            s1_loy_reg  <= loy_next;
            s1_hiy_reg  <= hiy_next;
            s1_slx_reg  <= 33'(in_item.self_x) - $signed({2'b00, in_item.self_a});
            s1_shx_reg  <= 33'(in_item.self_x) + $signed({2'b00, in_item.self_a});
            s1_sly_reg  <= 33'(in_item.self_y) - $signed({2'b00, in_item.self_b});
            s1_shy_reg  <= 33'(in_item.self_y) + $signed({2'b00, in_item.self_b});
            s1_ltx_reg  <= in_item.self_x < in_item.other_x;
            s1_lty_reg  <= in_item.self_y < in_item.other_y;
            s1_rad_reg  <= rad_next;
        end
    end

    // stage 2: offset from the clamped point, box overlap and box push
    logic signed [33:0]       cxe;
    logic signed [33:0]       cye;
    logic signed [33:0]       dx_next;
    logic signed [33:0]       dy_next;

    logic                     s2_v_reg;
    spcp_func_t               s2_func_reg;
    logic                     s2_push_reg;
    logic                     s2_dyn_reg;
    logic signed [33:0]       s2_dx_reg;
    logic signed [33:0]       s2_dy_reg;
    logic                     s2_hb_reg;
    logic signed [33:0]       s2_bmx_reg;
    logic signed [33:0]       s2_bmy_reg;
    logic [MAG_W-1:0]         s2_rad_reg;

    always_comb
    begin
        cxe = 34'(s1_cx_reg);
        cye = 34'(s1_cy_reg);
        if (cxe < 34'(s1_lox_reg))
            dx_next = cxe - 34'(s1_lox_reg);
        else if (cxe > 34'(s1_hix_reg))
            dx_next = cxe - 34'(s1_hix_reg);
        else
            dx_next = '0;
        if (cye < 34'(s1_loy_reg))
            dy_next = cye - 34'(s1_loy_reg);
        else if (cye > 34'(s1_hiy_reg))
            dy_next = cye - 34'(s1_hiy_reg);
        else
            dy_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_v_reg <= 1'b0;
        else if (adv)
            s2_v_reg <= s1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_func_reg <= s1_func_reg;
            s2_push_reg <= s1_push_reg;
            s2_dyn_reg  <= s1_dyn_reg;
            s2_dx_reg   <= dx_next;
            s2_dy_reg   <= dy_next;
            s2_hb_reg   <= (s1_slx_reg < s1_hix_reg) && (s1_shx_reg > s1_lox_reg) &&
                           (s1_sly_reg < s1_hiy_reg) && (s1_shy_reg > s1_loy_reg);
            s2_bmx_reg  <= s1_ltx_reg ? 34'(s1_lox_reg) - 34'(s1_shx_reg)
                                      : 34'(s1_hix_reg) - 34'(s1_slx_reg);
            s2_bmy_reg  <= s1_lty_reg ? 34'(s1_loy_reg) - 34'(s1_shy_reg)
                                      : 34'(s1_hiy_reg) - 34'(s1_sly_reg);
            s2_rad_reg  <= s1_rad_reg;
        end
    end

    // stage 3: magnitudes and signs of the offset
    logic signed [33:0]       dx_mag;
    logic signed [33:0]       dy_mag;

    logic                     s3_v_reg;
    spcp_func_t               s3_func_reg;
    logic                     s3_push_reg;
    logic                     s3_dyn_reg;
    logic                     s3_hb_reg;
    logic signed [33:0]       s3_bmx_reg;
    logic signed [33:0]       s3_bmy_reg;
    logic                     s3_xneg_reg;
    logic                     s3_yneg_reg;
    logic [MAG_W-1:0]         s3_ax_reg;
    logic [MAG_W-1:0]         s3_ay_reg;
    logic [MAG_W-1:0]         s3_rad_reg;

    assign dx_mag = s2_dx_reg[33] ? -s2_dx_reg : s2_dx_reg;
    assign dy_mag = s2_dy_reg[33] ? -s2_dy_reg : s2_dy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_v_reg <= 1'b0;
        else if (adv)
            s3_v_reg <= s2_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_func_reg <= s2_func_reg;
            s3_push_reg <= s2_push_reg;
            s3_dyn_reg  <= s2_dyn_reg;
            s3_hb_reg   <= s2_hb_reg;
            s3_bmx_reg  <= s2_bmx_reg;
            s3_bmy_reg  <= s2_bmy_reg;
            s3_xneg_reg <= s2_dx_reg[33];
            s3_yneg_reg <= s2_dy_reg[33];
            s3_ax_reg   <= dx_mag[MAG_W-1:0];
            s3_ay_reg   <= dy_mag[MAG_W-1:0];
            s3_rad_reg  <= s2_rad_reg;
        end
    end

    // stage 4: squares
    logic                     s4_v_reg;
    spcp_root_side_t          s4_side_reg;
    logic [PROD_W-1:0]        s4_sqx_reg;
    logic [PROD_W-1:0]        s4_sqy_reg;
    logic [PROD_W-1:0]        s4_r2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_v_reg <= 1'b0;
        else if (adv)
            s4_v_reg <= s3_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_side_reg.func  <= s3_func_reg;
            s4_side_reg.push  <= s3_push_reg;
            s4_side_reg.dyn   <= s3_dyn_reg;
            s4_side_reg.hit   <= s3_hb_reg;
            s4_side_reg.bmx   <= s3_bmx_reg;
            s4_side_reg.bmy   <= s3_bmy_reg;
            s4_side_reg.x_neg <= s3_xneg_reg;
            s4_side_reg.y_neg <= s3_yneg_reg;
            s4_side_reg.ax    <= s3_ax_reg;
            s4_side_reg.ay    <= s3_ay_reg;
            s4_side_reg.rad   <= s3_rad_reg;
            s4_sqx_reg        <= PROD_W'(s3_ax_reg) * PROD_W'(s3_ax_reg);
            s4_sqy_reg        <= PROD_W'(s3_ay_reg) * PROD_W'(s3_ay_reg);
            s4_r2_reg         <= PROD_W'(s3_rad_reg) * PROD_W'(s3_rad_reg);
        end
    end

    // stage 5: squared length and overlap test
    logic [PROD_W:0]          d2;
    logic                     hit_next;
    spcp_root_side_t          side_next;
    logic                     s5_v_reg;
    spcp_root_side_t          s5_side_reg;
    logic [PROD_W-1:0]        s5_n_reg;

    always_comb
    begin
        d2       = {1'b0, s4_sqx_reg} + {1'b0, s4_sqy_reg};
        hit_next = (s4_side_reg.func == FUNC_BB) ? s4_side_reg.hit
                                                 : (d2 <= {1'b0, s4_r2_reg});
        side_next     = s4_side_reg;
        side_next.hit = hit_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_v_reg <= 1'b0;
        else if (adv)
            s5_v_reg <= s4_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_side_reg <= side_next;
            s5_n_reg    <= d2[PROD_W-1:0];
        end
    end

    assign out_valid = s5_v_reg;
    assign out_side  = s5_side_reg;
    assign out_n     = s5_n_reg;

endmodule

`default_nettype wire

FILE: rtl/core/spcp_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

module spcp_sqrt
    import spcp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  in_valid,
    input  spcp_root_side_t       in_side,
    input  logic [PROD_W-1:0]     in_n,
    output logic                  out_valid,
    output spcp_root_side_t       out_side,
    output logic [MAG_W-1:0]      out_root
);

    localparam int TW = PROD_W + 1;

    logic                 v_reg    [MAG_W];
    spcp_root_side_t      side_reg [MAG_W];
    logic [PROD_W-1:0]    rem_reg  [MAG_W];
    logic [MAG_W-1:0]     root_reg [MAG_W];

    // one root bit per stage, most significant first
    for (genvar k = 0; k < MAG_W; k++)
    begin : g_stage
        localparam int B = MAG_W - 1 - k;

        logic               v_in;
        spcp_root_side_t    side_in;
        logic [PROD_W-1:0]  rem_in;
        logic [MAG_W-1:0]   root_in;
        logic [TW-1:0]      trial;
        logic               take;

        if (k == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign side_in = in_side;
            assign rem_in  = in_n;
            assign root_in = '0;
        end
        else
        begin : g_next
            assign v_in    = v_reg[k-1];
            assign side_in = side_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        // remainder holds n minus root squared
        assign trial = (TW'(root_in) << (B + 1)) | (TW'(1) << (2 * B));
        assign take  = {1'b0, rem_in} >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (adv)
                v_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                side_reg[k] <= side_in;
                rem_reg[k]  <= take ? rem_in - trial[PROD_W-1:0] : rem_in;
                root_reg[k] <= take ? (root_in | (MAG_W'(1) << B)) : root_in;
            end
        end
    end

    assign out_valid = v_reg[MAG_W-1];
    assign out_side  = side_reg[MAG_W-1];
    assign out_root  = root_reg[MAG_W-1];

endmodule

`default_nettype wire

FILE: rtl/core/spcp_scale.sv
`timescale 1ns / 1ps
`default_nettype none

module spcp_scale
    import spcp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  in_valid,
    input  spcp_root_side_t       in_side,
    input  logic [MAG_W-1:0]      in_root,
    output logic                  out_valid,
    output spcp_quot_side_t       out_side,
    output logic [MAG_W-1:0]      out_qx,
    output logic [MAG_W-1:0]      out_qy
);

    // push amount and special cases
    logic                 a_v_reg;
    spcp_quot_side_t      a_side_reg;
    logic [MAG_W-1:0]     a_ax_reg;
    logic [MAG_W-1:0]     a_ay_reg;
    logic [MAG_W-1:0]     a_dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_v_reg <= 1'b0;
        else if (adv)
            a_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_side_reg.func      <= in_side.func;
            a_side_reg.push      <= in_side.push;
            a_side_reg.dyn       <= in_side.dyn;
            a_side_reg.hit       <= in_side.hit;
            a_side_reg.bmx       <= in_side.bmx;
            a_side_reg.bmy       <= in_side.bmy;
            a_side_reg.x_neg     <= in_side.x_neg;
            a_side_reg.y_neg     <= in_side.y_neg;
            a_side_reg.dist_zero <= (in_root == '0);
            a_side_reg.over_pos  <= (in_root < in_side.rad);
            a_side_reg.amt       <= in_side.rad - in_root;
            a_ax_reg             <= in_side.ax;
            a_ay_reg             <= in_side.ay;
            a_dist_reg           <= in_root;
        end
    end

    // component times amount
    logic                 m_v_reg;
    spcp_quot_side_t      m_side_reg;
    logic [PROD_W-1:0]    m_nx_reg;
    logic [PROD_W-1:0]    m_ny_reg;
    logic [MAG_W-1:0]     m_dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_v_reg <= 1'b0;
        else if (adv)
            m_v_reg <= a_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_side_reg <= a_side_reg;
            m_nx_reg   <= PROD_W'(a_ax_reg) * PROD_W'(a_side_reg.amt);
            m_ny_reg   <= PROD_W'(a_ay_reg) * PROD_W'(a_side_reg.amt);
            m_dist_reg <= a_dist_reg;
        end
    end

    // restoring divide by the distance, one quotient bit per stage
    logic                 v_reg    [MAG_W];
    spcp_quot_side_t      side_reg [MAG_W];
    logic [PROD_W-1:0]    remx_reg [MAG_W];
    logic [PROD_W-1:0]    remy_reg [MAG_W];
    logic [MAG_W-1:0]     qx_reg   [MAG_W];
    logic [MAG_W-1:0]     qy_reg   [MAG_W];
    logic [MAG_W-1:0]     dist_reg [MAG_W];

    for (genvar k = 0; k < MAG_W; k++)
    begin : g_stage
        localparam int B = MAG_W - 1 - k;

        logic               v_in;
        spcp_quot_side_t    side_in;
        logic [PROD_W-1:0]  remx_in;
        logic [PROD_W-1:0]  remy_in;
        logic [MAG_W-1:0]   qx_in;
        logic [MAG_W-1:0]   qy_in;
        logic [MAG_W-1:0]   dist_in;
        logic [PROD_W-1:0]  trial;
        logic               takex;
        logic               takey;

        if (k == 0)
        begin : g_first
            assign v_in    = m_v_reg;
            assign side_in = m_side_reg;
            assign remx_in = m_nx_reg;
            assign remy_in = m_ny_reg;
            assign qx_in   = '0;
            assign qy_in   = '0;
            assign dist_in = m_dist_reg;
        end
        else
        begin : g_next
            assign v_in    = v_reg[k-1];
            assign side_in = side_reg[k-1];
            assign remx_in = remx_reg[k-1];
            assign remy_in = remy_reg[k-1];
            assign qx_in   = qx_reg[k-1];
            assign qy_in   = qy_reg[k-1];
            assign dist_in = dist_reg[k-1];
        end

        assign trial = PROD_W'(dist_in) << B;
        assign takex = remx_in >= trial;
        assign takey = remy_in >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (adv)
                v_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                side_reg[k] <= side_in;
                dist_reg[k] <= dist_in;
                remx_reg[k] <= takex ? remx_in - trial : remx_in;
                remy_reg[k] <= takey ? remy_in - trial : remy_in;
                qx_reg[k]   <= takex ? (qx_in | (MAG_W'(1) << B)) : qx_in;
                qy_reg[k]   <= takey ? (qy_in | (MAG_W'(1) << B)) : qy_in;
            end
        end
    end

    assign out_valid = v_reg[MAG_W-1];
    assign out_side  = side_reg[MAG_W-1];
    assign out_qx    = qx_reg[MAG_W-1];
    assign out_qy    = qy_reg[MAG_W-1];

endmodule

`default_nettype wire

FILE: rtl/core/shape_pair_collision_pushback.sv
`timescale 1ns / 1ps
`default_nettype none
// an accepted item passes through the front, square root, scaling and divider stages to the output register
// throughput: one item per cycle unless stalled; the 32-stage root and 32-stage divider are fully pipelined
// the whole pipeline holds while a finished result waits and the output is not taken
// reset: asynchronous, active low; clears the stage valid bits, the datapath is not reset

module shape_pair_collision_pushback
    import spcp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    spcp_in_if.sink       pair_in,
    spcp_out_if.source    result_out
);

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -34'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    logic               adv;
    logic               out_valid_reg;
    spcp_item_t         item;

    logic               f_valid;
    spcp_root_side_t    f_side;
    logic [PROD_W-1:0]  f_n;
    logic               r_valid;
    spcp_root_side_t    r_side;
    logic [MAG_W-1:0]   r_root;
    logic               q_valid;
    spcp_quot_side_t    q_side;
    logic [MAG_W-1:0]   q_x;
    logic [MAG_W-1:0]   q_y;

    // pipeline advances unless a result is waiting and not taken
    assign adv           = !out_valid_reg || result_out.ready;
    assign pair_in.ready = adv;

    assign item.func       = spcp_func_t'(pair_in.func);
    assign item.self_x     = pair_in.self_x;
    assign item.self_y     = pair_in.self_y;
    assign item.self_a     = pair_in.self_a;
    assign item.self_b     = pair_in.self_b;
    assign item.other_x    = pair_in.other_x;
    assign item.other_y    = pair_in.other_y;
    assign item.other_a    = pair_in.other_a;
    assign item.other_b    = pair_in.other_b;
    assign item.apply_push = pair_in.apply_push;
    assign item.dynamic    = pair_in.dynamic;

    spcp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (pair_in.valid),
        .in_item   (item),
        .out_valid (f_valid),
        .out_side  (f_side),
        .out_n     (f_n)
    );

    spcp_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (f_valid),
        .in_side   (f_side),
        .in_n      (f_n),
        .out_valid (r_valid),
        .out_side  (r_side),
        .out_root  (r_root)
    );

    spcp_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (r_valid),
        .in_side   (r_side),
        .in_root   (r_root),
        .out_valid (q_valid),
        .out_side  (q_side),
        .out_qx    (q_x),
        .out_qy    (q_y)
    );

    // final selection, sign and saturation
    logic               negx;
    logic               negy;
    logic signed [33:0] pxm;
    logic signed [33:0] pym;
    logic signed [33:0] px;
    logic signed [33:0] py;
    logic               mv_next;
    logic               gr_next;
    logic signed [33:0] mx_next;
    logic signed [33:0] my_next;

    logic               colliding_reg;
    logic               grounded_reg;
    logic signed [31:0] move_x_reg;
    logic signed [31:0] move_y_reg;
    logic               moved_reg;

    always_comb
    begin
        negx    = q_side.x_neg ^ (q_side.func == FUNC_BC);
        negy    = q_side.y_neg ^ (q_side.func == FUNC_BC);
        pxm     = q_side.dist_zero ? $signed({2'b00, q_side.amt}) : $signed({2'b00, q_x});
        pym     = q_side.dist_zero ? '0 : $signed({2'b00, q_y});
        px      = negx ? -pxm : pxm;
        py      = negy ? -pym : pym;
        mv_next = 1'b0;
        gr_next = 1'b0;
        mx_next = px;
        my_next = py;
        unique case (q_side.func)
            FUNC_CC:
            begin
                mv_next = q_side.hit && q_side.push && q_side.dyn;
            end
            FUNC_BB:
            begin
                mv_next = q_side.hit && q_side.push && q_side.dyn;
                mx_next = q_side.bmx;
                my_next = q_side.bmy;
            end
            FUNC_CB, FUNC_BC:
            begin
                mv_next = q_side.hit && q_side.push && q_side.over_pos && q_side.dyn;
                // push of the circle points mostly down
                gr_next = q_side.hit && q_side.push && q_side.over_pos &&
                          !q_side.dist_zero && q_side.y_neg && (q_y > q_x);
            end
            default:
            begin
                mv_next = 1'b0;
            end
        endcase
        if (!mv_next)
        begin
            mx_next = '0;
            my_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= q_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            colliding_reg <= q_side.hit;
            grounded_reg  <= gr_next;
            move_x_reg    <= sat32(mx_next);
            move_y_reg    <= sat32(my_next);
            moved_reg     <= mv_next;
        end
    end

    assign result_out.valid     = out_valid_reg;
    assign result_out.colliding = colliding_reg;
    assign result_out.grounded  = grounded_reg;
    assign result_out.move_x    = move_x_reg;
    assign result_out.move_y    = move_y_reg;
    assign result_out.moved     = moved_reg;

endmodule

`default_nettype wire
